### hdl/bol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_pkg
// Shared widths, codes and types of the bounded ordered list.
// ----------------------------------------------------------------------------
package bol_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 5;
  localparam int FIELD_W  = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

  localparam logic [FIELD_W-1:0] FOUND_NONE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_SEARCH     = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEL_HOLD       = 2'd0,
    SEL_LOAD       = 2'd1,
    SEL_FROM_LEFT  = 2'd2,
    SEL_FROM_RIGHT = 2'd3
  } cell_sel_t;

  typedef struct packed {
    cell_sel_t         sel;
    logic [WORD_W-1:0] word;
  } cell_ctl_t;

endpackage

### hdl/bol_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_req_if
// Command channel: valid/ready handshake carrying one command beat.
// ----------------------------------------------------------------------------
interface bol_req_if import bol_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [WORD_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink   (input valid, cmd, value, position, output ready);
endinterface

### hdl/bol_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_rsp_if
// Result channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface bol_rsp_if import bol_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [FIELD_W-1:0] found_index;
  logic [FIELD_W-1:0]        length;

  modport source (output valid, status, found_index, length, input ready);
  modport sink   (input valid, status, found_index, length, output ready);
endinterface

### hdl/bol_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_cell
// One list slot: holds a word, loads, shifts from a neighbor, compares a key.
// ----------------------------------------------------------------------------
module bol_cell import bol_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [WORD_W-1:0] left,
  input  logic [WORD_W-1:0] right,
  output logic [WORD_W-1:0] data,
  output logic              match
);

  always_ff @(posedge clk) begin
    case (ctl.sel)
      SEL_LOAD:       data <= ctl.word;
      SEL_FROM_LEFT:  data <= left;
      SEL_FROM_RIGHT: data <= right;
      default:        data <= data;
    endcase
  end

  assign match = (data == ctl.word);

endmodule

### hdl/bounded_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list
// Ordered list of up to CAPACITY words built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Push, pop and insert update all cells as the command is taken: every cell
// picks its next word from itself, its left or right neighbor or the incoming
// word, and the result beat is registered at the same edge. A search latches
// all cell compares as it is taken, then walks the registered match row one
// entry per cycle until the first hit or the last entry, holding the command
// port meanwhile. One command is in flight at a time; a new command is taken
// while the previous result beat is being taken.
module bounded_ordered_list import bol_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  bol_req_if.sink      req,
  bol_rsp_if.source    rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CAPACITY-1:0] match_vec;
  logic [CNT_W-1:0]    scan_idx;
  logic [CNT_W-1:0]    scan_inc;
  logic [CMP_W-1:0]    scan_ext;
  logic [CMP_W-1:0]    count_ext;
  logic [CMP_W-1:0]    count_ext_next;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    gap;

  logic                rsp_valid;
  status_t             rsp_status;
  logic [FIELD_W-1:0]  rsp_found;
  logic [FIELD_W-1:0]  rsp_length;

  logic                fire;
  logic                full;
  logic                do_open;
  logic                do_close;
  status_t             st;
  logic                scan_hit;
  logic                scan_last;

  logic [WORD_W-1:0]   cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  cell_ctl_t           cell_ctl  [CAPACITY];

  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign fire      = req.valid && req.ready;

  assign count_ext      = CMP_W'(count);
  assign count_ext_next = CMP_W'(count_next);
  assign pos_ext        = CMP_W'(req.position);
  assign scan_ext       = CMP_W'(scan_idx);
  assign full           = (count == CNT_W'(CAPACITY));

  always_comb begin
    st       = ST_OK;
    do_open  = 1'b0;
    do_close = 1'b0;
    gap      = '0;
    case (req.cmd)
      CMD_PUSH_FRONT: begin
        if (full) st = ST_FULL;
        else do_open = 1'b1;
      end
      CMD_PUSH_BACK: begin
        gap = count_ext;
        if (full) st = ST_FULL;
        else do_open = 1'b1;
      end
      CMD_POP_FRONT: begin
        if (count == '0) st = ST_EMPTY;
        else do_close = 1'b1;
      end
      CMD_POP_BACK: begin
        gap = count_ext - CMP_W'(1);
        if (count == '0) st = ST_EMPTY;
        else do_close = 1'b1;
      end
      CMD_INSERT: begin
        gap = pos_ext;
        if (pos_ext > count_ext) st = ST_BADPOS;
        else if (full) st = ST_FULL;
        else do_open = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_open) count_next = count + CNT_W'(1);
    else if (do_close) count_next = count - CNT_W'(1);
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_W-1:0] left_word;
      logic [WORD_W-1:0] right_word;

      if (i == 0) begin : g_first
        assign left_word = '0;
      end else begin : g_mid_l
        assign left_word = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_word = '0;
      end else begin : g_mid_r
        assign right_word = cell_data[i+1];
      end

      always_comb begin
        cell_ctl[i].word = req.value;
        cell_ctl[i].sel  = SEL_HOLD;
        if (fire && do_open) begin
          if (CMP_W'(i) > gap) cell_ctl[i].sel = SEL_FROM_LEFT;
          else if (CMP_W'(i) == gap) cell_ctl[i].sel = SEL_LOAD;
        end else if (fire && do_close) begin
          if (CMP_W'(i) >= gap) cell_ctl[i].sel = SEL_FROM_RIGHT;
        end
      end

      bol_cell u_cell (
        .clk   (clk),
        .ctl   (cell_ctl[i]),
        .left  (left_word),
        .right (right_word),
        .data  (cell_data[i]),
        .match (cell_match[i])
      );
    end
  endgenerate

  assign scan_inc  = scan_idx + CNT_W'(1);
  assign scan_hit  = match_vec[0];
  assign scan_last = (scan_inc >= count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (fire) begin
            if (req.cmd == CMD_SEARCH) begin
              state     <= S_SCAN;
              rsp_valid <= 1'b0;
            end else begin
              count     <= count_next;
              rsp_valid <= 1'b1;
            end
          end else if (rsp.ready) begin
            rsp_valid <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_hit || scan_last) begin
            state     <= S_IDLE;
            rsp_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && fire) begin
      if (req.cmd == CMD_SEARCH) begin
        for (int k = 0; k < CAPACITY; k++) begin
          match_vec[k] <= cell_match[k] && (CNT_W'(k) < count);
        end
        scan_idx <= '0;
      end else begin
        rsp_status <= st;
        rsp_found  <= FOUND_NONE;
        rsp_length <= count_ext_next[FIELD_W-1:0];
      end
    end else if (state == S_SCAN) begin
      match_vec <= match_vec >> 1;
      scan_idx  <= scan_inc;
      if (scan_hit || scan_last) begin
        rsp_status <= ST_OK;
        rsp_found  <= scan_hit ? scan_ext[FIELD_W-1:0] : FOUND_NONE;
        rsp_length <= count_ext[FIELD_W-1:0];
      end
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.found_index = rsp_found;
  assign rsp.length      = rsp_length;

  a_scan_no_beat: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !rsp_valid)
    else $error("result beat pending during search");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_quick_beat: assert property (@(posedge clk) disable iff (rst)
    (fire && req.cmd != CMD_SEARCH) |=> rsp_valid)
    else $error("no result beat after list update");

  a_length_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_length == count_ext[FIELD_W-1:0]))
    else $error("reported length differs from entry count");

endmodule

### tb/tb_bounded_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_ordered_list
// Self-checking bench for the bounded ordered list. A queue-fed driver sends
// directed and biased random commands on the request channel. A monitor keeps
// a shadow list, predicts every result beat and checks it field by field.
// Four phases vary idle cycles on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module tb_bounded_ordered_list;
  import bol_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 320;
  localparam int KEY_POOL       = 8;
  localparam int NUM_PHASES     = 4;

  localparam int BIAS_GROW   = 0;
  localparam int BIAS_SHRINK = 1;
  localparam int BIAS_MIXED  = 2;

  localparam int SEND_IDLE  [NUM_PHASES] = '{0, 80, 0, 13};
  localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 80, 13};

  localparam cmd_t CMD_LIST [6] = '{CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_POP_FRONT,
                                    CMD_POP_BACK, CMD_INSERT, CMD_SEARCH};

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] EDGE_WORDS [4] = '{WORD_MIN, WORD_MAX, 32'sd0, -32'sd1};

  typedef struct {
    cmd_t                     cmd;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } list_cmd_t;

  typedef struct {
    status_t            status;
    logic [FIELD_W-1:0] found_index;
    logic [FIELD_W-1:0] length;
  } list_rsp_t;

  logic clk;
  logic rst;

  bol_req_if req_bus ();
  bol_rsp_if rsp_bus ();

  bounded_ordered_list DUT (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  list_cmd_t                cmds_pending [$];
  list_rsp_t                results_due  [$];
  logic signed [WORD_W-1:0] list_words   [CAPACITY];
  int                       list_len;
  int                       gen_len;
  logic signed [WORD_W-1:0] key_pool     [KEY_POOL];

  int   send_idle_pct;
  int   recv_stall_pct;
  logic req_took;
  int   items_queued;
  int   fails;
  int   quiet_cycles;
  int   cmd_seen    [6];
  int   status_seen [4];
  int   search_hits;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic list_rsp_t list_apply(list_cmd_t c);
    list_rsp_t r;
    int        at;
    r.status      = ST_OK;
    r.found_index = FOUND_NONE;
    at            = -1;
    case (c.cmd)
      CMD_PUSH_FRONT: at = 0;
      CMD_PUSH_BACK:  at = list_len;
      CMD_INSERT: begin
        if (int'(c.position) > list_len) r.status = ST_BADPOS;
        else at = int'(c.position);
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (c.cmd == CMD_POP_FRONT)
            for (int i = 0; i < list_len - 1; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      CMD_SEARCH: begin
        for (int i = list_len - 1; i >= 0; i--)
          if (list_words[i] == c.value) r.found_index = FIELD_W'(i);
      end
      default: ;
    endcase
    if (at >= 0) begin
      if (list_len >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        for (int i = list_len; i > at; i--) list_words[i] = list_words[i - 1];
        list_words[at] = c.value;
        list_len++;
      end
    end
    r.length = FIELD_W'(list_len);
    return r;
  endfunction

  // gen_len tracks the length the queued commands will leave, to aim inserts
  task automatic queue_cmd(cmd_t c, logic signed [WORD_W-1:0] v, int p);
    list_cmd_t item;
    item.cmd      = c;
    item.value    = v;
    item.position = POS_W'(p);
    cmds_pending.insert(cmds_pending.size(), item);
    items_queued++;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: if (gen_len < CAPACITY) gen_len++;
      CMD_POP_FRONT, CMD_POP_BACK:   if (gen_len > 0) gen_len--;
      CMD_INSERT:                    if (p <= gen_len && gen_len < CAPACITY) gen_len++;
      default: ;
    endcase
  endtask

  task automatic queue_random(int bias);
    int                       w [6];
    int                       roll;
    int                       k;
    int                       pos;
    logic signed [WORD_W-1:0] v;
    case (bias)
      BIAS_GROW:   w = '{20, 20, 5, 5, 30, 20};
      BIAS_SHRINK: w = '{5, 5, 30, 30, 5, 25};
      default:     w = '{15, 15, 15, 15, 20, 20};
    endcase
    roll = $urandom_range(99);
    k    = 0;
    while (roll >= w[k]) begin
      roll -= w[k];
      k++;
    end
    roll = $urandom_range(99);
    if (roll < 45) v = key_pool[$urandom_range(KEY_POOL - 1)];
    else if (roll < 60) v = EDGE_WORDS[$urandom_range(3)];
    else v = $urandom;
    if (CMD_LIST[k] == CMD_INSERT && $urandom_range(4) != 0) pos = $urandom_range(gen_len);
    else pos = $urandom_range(CAPACITY);
    queue_cmd(CMD_LIST[k], v, pos);
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (!req_bus.valid || req_took) begin
        if (cmds_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_bus.valid    <= 1'b1;
          req_bus.cmd      <= cmds_pending[0].cmd;
          req_bus.value    <= cmds_pending[0].value;
          req_bus.position <= cmds_pending[0].position;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    list_rsp_t want;
    list_cmd_t got;
    if (rst) begin
      req_took <= 1'b0;
    end else begin
      req_took <= req_bus.valid && req_bus.ready;
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (results_due.size() == 0) begin
          $error("result beat with no command outstanding");
          fails++;
        end else begin
          want = results_due[0];
          results_due.delete(0);
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
            fails++;
          end
          if (rsp_bus.found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d",
                   $signed(want.found_index), $signed(rsp_bus.found_index));
            fails++;
          end
          if (rsp_bus.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, rsp_bus.length);
            fails++;
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        got.cmd      = cmd_t'(req_bus.cmd);
        got.value    = req_bus.value;
        got.position = req_bus.position;
        want         = list_apply(got);
        results_due.insert(results_due.size(), want);
        cmds_pending.delete(0);
        cmd_seen[req_bus.cmd]++;
        status_seen[want.status]++;
        if (got.cmd == CMD_SEARCH && want.found_index != FOUND_NONE) search_hits++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat in %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int bias;
    int burst;
    int target;
    rst              = 1'b1;
    req_bus.valid    = 1'b0;
    req_bus.cmd      = CMD_PUSH_FRONT;
    req_bus.value    = '0;
    req_bus.position = '0;
    rsp_bus.ready    = 1'b0;
    list_len         = 0;
    gen_len          = 0;
    items_queued     = 0;
    fails            = 0;
    quiet_cycles     = 0;
    search_hits      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      if (ph == 0) begin
        queue_cmd(CMD_POP_FRONT, 32'sd0, 0);
        queue_cmd(CMD_POP_BACK, 32'sd0, 0);
        queue_cmd(CMD_SEARCH, 32'sd0, 0);
        queue_cmd(CMD_INSERT, 32'sd5, 1);
        queue_cmd(CMD_INSERT, WORD_MIN, 0);
        queue_cmd(CMD_PUSH_FRONT, WORD_MAX, 0);
        queue_cmd(CMD_PUSH_BACK, 32'sd0, 0);
        queue_cmd(CMD_PUSH_BACK, -32'sd1, 0);
        queue_cmd(CMD_SEARCH, -32'sd1, 0);
        queue_cmd(CMD_SEARCH, 32'sd7, 0);
        queue_cmd(CMD_INSERT, 32'sh5555_5555, 4);
        queue_cmd(CMD_INSERT, 32'sh2AAA_AAAA, 2);
        queue_cmd(CMD_INSERT, 32'sd9, CAPACITY);
        queue_cmd(CMD_POP_BACK, 32'sd0, 0);
        queue_cmd(CMD_POP_FRONT, 32'sd0, 0);
        while (gen_len < CAPACITY) queue_cmd(CMD_PUSH_BACK, key_pool[gen_len % KEY_POOL], 0);
        queue_cmd(CMD_PUSH_FRONT, 32'sd1, 0);
        queue_cmd(CMD_PUSH_BACK, 32'sd1, 0);
        queue_cmd(CMD_INSERT, 32'sd1, CAPACITY);
        queue_cmd(CMD_INSERT, 32'sd1, 0);
        queue_cmd(CMD_SEARCH, key_pool[(CAPACITY - 1) % KEY_POOL], 0);
      end
      target = items_queued + PHASE_ITEMS;
      while (items_queued < target) begin
        bias  = $urandom_range(BIAS_MIXED);
        burst = $urandom_range(40, 8);
        repeat (burst) queue_random(bias);
      end
      while (cmds_pending.size() != 0 || results_due.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d commands: push %0d/%0d, pop %0d/%0d, insert %0d, search %0d (%0d hits)",
             items_queued, cmd_seen[CMD_PUSH_FRONT], cmd_seen[CMD_PUSH_BACK],
             cmd_seen[CMD_POP_FRONT], cmd_seen[CMD_POP_BACK], cmd_seen[CMD_INSERT],
             cmd_seen[CMD_SEARCH], search_hits);
    $display("status counts: ok %0d, empty %0d, bad position %0d, full %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BADPOS],
             status_seen[ST_FULL]);
    if (fails == 0 && results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
